FILE: design/app_image_end_finder_defines.svh
// Assertion helpers used by the image end finder design file.
`ifndef APP_IMAGE_END_FINDER_DEFINES_SVH
`define APP_IMAGE_END_FINDER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define AEF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define AEF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: design/aef_pkg.sv
package aef_pkg;

    localparam int LENGTH_BITS_DEF  = 25;
    localparam int MAX_SEGMENTS_DEF = 32;

    localparam logic [7:0] MAGIC_BYTE  = 8'hE9;
    localparam int         HEADER_LEN  = 24;
    localparam int         SEG_CNT_OFS = 1;
    localparam int         CHIP_OFS    = 12;
    localparam int         END_W       = 25;
    localparam logic [END_W-1:0] END_MAX = '1;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_BAD_MAGIC = 3'd2;
    localparam logic [2:0] ST_BAD_CHIP  = 3'd3;
    localparam logic [2:0] ST_BAD_SEGS  = 3'd4;
    localparam logic [2:0] ST_TRUNC     = 3'd5;

    // platform codes
    localparam logic [2:0] PF_BASE    = 3'd0;
    localparam logic [2:0] PF_S2      = 3'd1;
    localparam logic [2:0] PF_C3      = 3'd2;
    localparam logic [2:0] PF_S3      = 3'd3;
    localparam logic [2:0] PF_C2      = 3'd4;
    localparam logic [2:0] PF_UNKNOWN = 3'd5;

    localparam logic [7:0] CHIP_BASE = 8'h00;
    localparam logic [7:0] CHIP_S2   = 8'h02;
    localparam logic [7:0] CHIP_C3   = 8'h05;
    localparam logic [7:0] CHIP_S3   = 8'h09;
    localparam logic [7:0] CHIP_C2   = 8'h0C;

    function automatic logic [2:0] chip_to_platform(input logic [7:0] chip);
        logic [2:0] pf;
        unique case (chip)
            CHIP_BASE: pf = PF_BASE;
            CHIP_S2:   pf = PF_S2;
            CHIP_C3:   pf = PF_C3;
            CHIP_S3:   pf = PF_S3;
            CHIP_C2:   pf = PF_C2;
            default:   pf = PF_UNKNOWN;
        endcase
        return pf;
    endfunction

    // summary flags handed from the byte stage to the end-check stage
    typedef struct packed {
        logic       magic_ok;
        logic [2:0] platform;
        logic       segs_zero;
        logic       walk_complete;
        logic       walk_failed;
    } t_fin_flags;

endpackage

FILE: design/app_image_end_finder.sv
// Application image end finder. Takes one image byte per cycle on the slave stream
// (s_axis_tlast marks the final byte) and, for each image, returns one result item on
// the master stream: status, platform code and image end (header magic, chip id at
// offset 12, segment count 1..MAX_SEGMENTS at offset 1, segment header walk from
// offset 24, end taken to the next 16-byte boundary past the walk, plus the 32-byte
// trailer). A new byte is taken every cycle, except that a final byte waits in the
// input register while the previous result still sits in the end-check stage behind
// a stalled master stream. The final byte passes from the input register through the
// byte stage (segment-size adder) to the end-check stage (rounding adder, compares),
// which feeds the output register of the master stream. After the final byte the block
// is back at its reset state, so the next image may follow at once.
`include "app_image_end_finder_defines.svh"

module app_image_end_finder
    import aef_pkg::*;
#(
    parameter int LENGTH_BITS  = LENGTH_BITS_DEF,
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [2:0] status, [5:3] platform, [30:6] image_end
);

    localparam int L     = LENGTH_BITS;
    localparam int SUM_W = ((L > 32) ? L : 32) + 2;
    localparam int WIDE  = ((L + 2) > END_W) ? (L + 2) : END_W;

    localparam logic [L-1:0] POS_ZERO  = '0;
    localparam logic [L-1:0] POS_SEG   = L'(SEG_CNT_OFS);
    localparam logic [L-1:0] POS_CHIP  = L'(CHIP_OFS);
    localparam logic [L-1:0] POS_HDR   = L'(HEADER_LEN);
    localparam logic [7:0]   SEG_LIMIT = 8'(MAX_SEGMENTS);

    // input register
    logic         r_in_valid;
    logic [7:0]   r_in_byte;
    logic         r_in_last;

    // walk state
    logic [L-1:0] r_pos, n_pos;
    logic         r_magic, n_magic;
    logic [7:0]   r_chip, n_chip;
    logic [7:0]   r_segs, n_segs;
    logic [L-1:0] r_nha, n_nha;
    logic [31:0]  r_size, n_size;
    logic         r_complete, n_complete;
    logic         r_failed, n_failed;
    logic [L-1:0] n_len;

    // end-check stage
    logic         r_fin_valid;
    logic [L-1:0] r_fin_len;
    logic [L-1:0] r_fin_nha;
    t_fin_flags   r_fin_flags;
    t_fin_flags   n_fin_flags;

    // output register
    logic         r_out_valid;
    logic [2:0]   r_out_status;
    logic [2:0]   r_out_platform;
    logic [END_W-1:0] r_out_end;

    logic out_free, fin_free, fin_move, proc, in_free;

    assign out_free = !r_out_valid || m_axis_tready;
    assign fin_move = r_fin_valid && out_free;
    assign fin_free = !r_fin_valid || out_free;
    // only the final byte of an image needs room further down
    assign proc     = r_in_valid && (!r_in_last || fin_free);
    assign in_free  = !r_in_valid || proc;
    assign s_axis_tready = in_free;

    // byte stage
    logic [L-1:0]     diff;
    logic [31:0]      gathered;
    logic [SUM_W-1:0] nxt;

    always_comb begin
        n_magic    = r_magic;
        n_segs     = r_segs;
        n_chip     = r_chip;
        n_nha      = r_nha;
        n_size     = r_size;
        n_complete = r_complete;
        n_failed   = r_failed;
        n_pos      = r_pos;
        n_len      = r_pos;
        diff       = r_pos - r_nha;
        gathered   = r_size | (32'(r_in_byte) << {diff[1:0], 3'b000});
        nxt        = SUM_W'(r_nha) + SUM_W'(8) + SUM_W'(gathered);

        if (r_pos == POS_ZERO) begin
            n_magic = (r_in_byte == MAGIC_BYTE);
        end
        if (r_pos == POS_SEG) begin
            n_segs = (r_in_byte >= 8'd1 && r_in_byte <= SEG_LIMIT) ? r_in_byte : 8'd0;
        end
        if (r_pos == POS_CHIP) begin
            n_chip = r_in_byte;
        end

        // size word sits in bytes 4..7 of each segment header
        if (n_segs != 8'd0 && !r_complete && !r_failed && r_pos >= r_nha
                && diff[L-1:3] == '0 && diff[2]) begin
            if (diff[1:0] == 2'd3) begin
                n_size = '0;
                if (nxt[SUM_W-1:L] != '0) begin
                    n_failed = 1'b1;
                end else begin
                    n_nha  = nxt[L-1:0];
                    n_segs = n_segs - 8'd1;
                    if (n_segs == 8'd0) begin
                        n_complete = 1'b1;
                    end
                end
            end else begin
                n_size = gathered;
            end
        end

        // saturate the byte counter
        if (&r_pos) begin
            n_failed = 1'b1;
        end else begin
            n_pos = r_pos + L'(1);
            n_len = r_pos + L'(1);
        end

        n_fin_flags.magic_ok      = n_magic;
        n_fin_flags.platform      = chip_to_platform(n_chip);
        n_fin_flags.segs_zero     = (n_segs == 8'd0);
        n_fin_flags.walk_complete = n_complete;
        n_fin_flags.walk_failed   = n_failed;
    end

    // end-check stage
    logic [WIDE-1:0]  end_pos;
    logic [2:0]       fin_status;
    logic [2:0]       fin_platform;
    logic [END_W-1:0] fin_end;

    always_comb begin
        end_pos      = ((WIDE'(r_fin_nha) + WIDE'(16)) & ~WIDE'(15)) + WIDE'(32);
        fin_status   = ST_OK;
        fin_platform = PF_UNKNOWN;
        fin_end      = '0;
        priority if (r_fin_len < POS_HDR) begin
            fin_status = ST_SHORT;
        end else if (!r_fin_flags.magic_ok) begin
            fin_status = ST_BAD_MAGIC;
        end else begin
            fin_platform = r_fin_flags.platform;
            priority if (r_fin_flags.platform == PF_UNKNOWN) begin
                fin_status = ST_BAD_CHIP;
            end else if (r_fin_flags.segs_zero && !r_fin_flags.walk_complete) begin
                fin_status = ST_BAD_SEGS;
            end else if (r_fin_flags.walk_failed || !r_fin_flags.walk_complete) begin
                fin_status = ST_TRUNC;
            end else if (end_pos > WIDE'(r_fin_len) || end_pos > WIDE'(END_MAX)) begin
                fin_status = ST_TRUNC;
            end else begin
                fin_end = end_pos[END_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_pos       <= '0;
            r_magic     <= 1'b0;
            r_chip      <= '0;
            r_segs      <= '0;
            r_nha       <= POS_HDR;
            r_size      <= '0;
            r_complete  <= 1'b0;
            r_failed    <= 1'b0;
            r_fin_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_free) begin
                r_in_valid <= s_axis_tvalid;
            end

            if (proc && r_in_last) begin
                // image done: back to the reset state for the next one
                r_pos      <= '0;
                r_magic    <= 1'b0;
                r_chip     <= '0;
                r_segs     <= '0;
                r_nha      <= POS_HDR;
                r_size     <= '0;
                r_complete <= 1'b0;
                r_failed   <= 1'b0;
            end else if (proc) begin
                r_pos      <= n_pos;
                r_magic    <= n_magic;
                r_chip     <= n_chip;
                r_segs     <= n_segs;
                r_nha      <= n_nha;
                r_size     <= n_size;
                r_complete <= n_complete;
                r_failed   <= n_failed;
            end

            if (proc && r_in_last) begin
                r_fin_valid <= 1'b1;
            end else if (fin_move) begin
                r_fin_valid <= 1'b0;
            end

            if (fin_move) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_free) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
        if (proc && r_in_last) begin
            r_fin_len   <= n_len;
            r_fin_nha   <= n_nha;
            r_fin_flags <= n_fin_flags;
        end
        if (fin_move) begin
            r_out_status   <= fin_status;
            r_out_platform <= fin_platform;
            r_out_end      <= fin_end;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_end, r_out_platform, r_out_status};

    `AEF_ASSERT_SAME(a_end_only_when_ok, i_clk, i_rst_n,
        r_out_valid && r_out_status != ST_OK, r_out_end == '0)
    `AEF_ASSERT_SAME(a_ok_has_known_chip, i_clk, i_rst_n,
        r_out_valid && r_out_status == ST_OK, r_out_platform != PF_UNKNOWN)
    `AEF_ASSERT_NEXT(a_reset_after_last, i_clk, i_rst_n,
        proc && r_in_last, r_pos == '0 && r_nha == POS_HDR && r_fin_valid)
    `AEF_ASSERT_NEXT(a_fin_held_on_stall, i_clk, i_rst_n,
        r_fin_valid && !out_free, r_fin_valid)

endmodule

FILE: test/tb.sv
module tb;
    import aef_pkg::*;

    localparam int LB = LENGTH_BITS_DEF;
    localparam logic [LB-1:0] POS_LIMIT = '1;

    typedef enum int {LEN_EXACT, LEN_OVER, LEN_UNDER, LEN_FIXED} t_len_mode;

    typedef struct {
        logic [7:0] data;
        logic       fin;
        bit         drain;
    } t_byte_item;

    typedef struct packed {
        logic [END_W-1:0] image_end;
        logic [2:0]       platform;
        logic [2:0]       status;
    } t_end_report;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // [7:0] data_byte
    logic        s_axis_tlast = 1'b0; // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // [2:0] status, [5:3] platform, [30:6] image_end

    app_image_end_finder i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    t_byte_item  bytes_to_send[$];
    t_end_report image_results[$];
    t_byte_item  next_byte;
    logic [7:0]  known_chips[5] = '{CHIP_BASE, CHIP_S2, CHIP_C3, CHIP_S3, CHIP_C2};

    int mismatches = 0;
    int images_made = 0;
    int issued_count = 0;
    int taken_count = 0;
    int gap_left = 0;
    int stall_left = 0;
    int gap_pct = 10;
    int stall_pct = 15;

    // image walk state, mirrors what the block tracks per image
    logic [LB-1:0] img_pos = '0;
    logic          magic_good = 1'b0;
    logic [7:0]    chip_id = '0;
    logic [7:0]    segs_left = '0;
    logic [LB:0]   seg_hdr_at = (LB+1)'(HEADER_LEN);
    logic [31:0]   seg_size = '0;
    logic          walk_done = 1'b0;
    logic          walk_bad = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("tb: done, errors");
        $finish;
    end

    task automatic take_image_byte(input logic [7:0] b, input logic fin);
        logic [LB-1:0]   p;
        logic [LB-1:0]   len;
        logic [LB:0]     off;
        logic [33:0]     nxt;
        logic [LB+1:0]   e;
        t_end_report     r;
        p = img_pos;
        if (p == 0)
            magic_good = (b == MAGIC_BYTE);
        if (p == SEG_CNT_OFS)
            segs_left = (b >= 1 && b <= MAX_SEGMENTS_DEF) ? b : 8'd0;
        if (p == CHIP_OFS)
            chip_id = b;

        if (segs_left != 0 && !walk_done && !walk_bad && {1'b0, p} >= seg_hdr_at) begin
            off = {1'b0, p} - seg_hdr_at;
            // size word sits in bytes 4..7 of each segment header, little endian
            if (off >= 4 && off <= 7) begin
                seg_size = seg_size | (32'(b) << (8 * (off - 4)));
                if (off == 7) begin
                    nxt = 34'(seg_hdr_at) + 34'd8 + 34'(seg_size);
                    seg_size = '0;
                    if (nxt > 34'(POS_LIMIT)) begin
                        walk_bad = 1'b1;
                    end else begin
                        seg_hdr_at = nxt[LB:0];
                        segs_left = segs_left - 8'd1;
                        if (segs_left == 0)
                            walk_done = 1'b1;
                    end
                end
            end
        end

        // saturate the byte counter
        if (p == POS_LIMIT) begin
            walk_bad = 1'b1;
            len = POS_LIMIT;
        end else begin
            img_pos = p + 1'b1;
            len = p + 1'b1;
        end

        if (fin) begin
            r.status = ST_OK;
            r.platform = PF_UNKNOWN;
            r.image_end = '0;
            if (len < HEADER_LEN) begin
                r.status = ST_SHORT;
            end else if (!magic_good) begin
                r.status = ST_BAD_MAGIC;
            end else begin
                case (chip_id)
                    CHIP_BASE: r.platform = PF_BASE;
                    CHIP_S2:   r.platform = PF_S2;
                    CHIP_C3:   r.platform = PF_C3;
                    CHIP_S3:   r.platform = PF_S3;
                    CHIP_C2:   r.platform = PF_C2;
                    default:   r.platform = PF_UNKNOWN;
                endcase
                if (r.platform == PF_UNKNOWN) begin
                    r.status = ST_BAD_CHIP;
                end else if (segs_left == 0 && !walk_done) begin
                    r.status = ST_BAD_SEGS;
                end else if (walk_bad || !walk_done) begin
                    r.status = ST_TRUNC;
                end else begin
                    // pad to 16 bytes, then add the trailer
                    e = ({1'b0, seg_hdr_at} + (LB+2)'(16)) & ~(LB+2)'(15);
                    e = e + (LB+2)'(32);
                    if (e > (LB+2)'(len) || e > (LB+2)'(END_MAX))
                        r.status = ST_TRUNC;
                    else
                        r.image_end = e[END_W-1:0];
                end
            end
            image_results.push_back(r);

            img_pos = '0;
            magic_good = 1'b0;
            chip_id = '0;
            segs_left = '0;
            seg_hdr_at = (LB+1)'(HEADER_LEN);
            seg_size = '0;
            walk_done = 1'b0;
            walk_bad = 1'b0;
        end
    endtask

    // Build one image: header, segment headers with random data, then pad or cut to length.
    // A nonzero big_size replaces the first segment size and ends the walk there.
    task automatic make_image(input logic [7:0] magic, input logic [7:0] seg_byte,
                              input logic [7:0] chip, input int size_max,
                              input logic [31:0] big_size, input t_len_mode mode,
                              input int fixed_len, input bit drain);
        logic [7:0]  img[$];
        logic [31:0] sz;
        int          nwalk;
        int          target;
        int          e;
        for (int i = 0; i < HEADER_LEN; i++)
            img.push_back(8'($urandom));
        img[0] = magic;
        img[SEG_CNT_OFS] = seg_byte;
        img[CHIP_OFS] = chip;
        nwalk = (seg_byte >= 1 && seg_byte <= MAX_SEGMENTS_DEF) ? seg_byte : $urandom_range(1, 3);
        for (int s = 0; s < nwalk; s++) begin
            sz = (big_size != 0) ? big_size : 32'($urandom_range(0, size_max));
            repeat (4) img.push_back(8'($urandom));
            for (int k = 0; k < 4; k++)
                img.push_back(sz[8*k +: 8]);
            if (big_size != 0)
                break;
            repeat (sz) img.push_back(8'($urandom));
        end
        e = ((img.size() + 16) & ~15) + 32;
        if (big_size != 0 && mode != LEN_FIXED)
            target = img.size() + $urandom_range(0, 24);
        else
            case (mode)
                LEN_EXACT: target = e;
                LEN_OVER:  target = e + $urandom_range(1, 24);
                LEN_UNDER: target = $urandom_range(HEADER_LEN, e - 1);
                default:   target = fixed_len;
            endcase
        while (img.size() < target)
            img.push_back(8'($urandom));
        while (img.size() > target)
            void'(img.pop_back());
        foreach (img[i])
            bytes_to_send.push_back('{data: img[i], fin: (i == img.size() - 1),
                                      drain: (drain && i == 0)});
        images_made++;
    endtask

    initial begin
        int         pick;
        bit         d;
        logic [7:0] m;
        logic [7:0] c;

        // directed images
        make_image(MAGIC_BYTE, 8'd1, CHIP_BASE, 0, 0, LEN_FIXED, 1, 0);
        make_image(MAGIC_BYTE, 8'd1, CHIP_BASE, 0, 0, LEN_FIXED, HEADER_LEN - 1, 0);
        make_image(MAGIC_BYTE, 8'd1, CHIP_BASE, 0, 0, LEN_FIXED, HEADER_LEN, 0);
        make_image(8'h00, 8'd1, CHIP_S2, 4, 0, LEN_EXACT, 0, 0);
        make_image(8'hFF, 8'd1, CHIP_S2, 4, 0, LEN_EXACT, 0, 0);
        foreach (known_chips[i])
            make_image(MAGIC_BYTE, 8'd1, known_chips[i], 0, 0, LEN_EXACT, 0, 0);
        make_image(MAGIC_BYTE, 8'd1, 8'h01, 4, 0, LEN_EXACT, 0, 0);
        make_image(MAGIC_BYTE, 8'd1, 8'hFF, 4, 0, LEN_EXACT, 0, 0);
        make_image(MAGIC_BYTE, 8'd0, CHIP_C3, 4, 0, LEN_EXACT, 0, 0);
        make_image(MAGIC_BYTE, 8'(MAX_SEGMENTS_DEF + 1), CHIP_C3, 4, 0, LEN_EXACT, 0, 0);
        make_image(MAGIC_BYTE, 8'hFF, CHIP_C3, 4, 0, LEN_EXACT, 0, 0);
        make_image(MAGIC_BYTE, 8'(MAX_SEGMENTS_DEF), CHIP_S3, 0, 0, LEN_EXACT, 0, 0);
        make_image(MAGIC_BYTE, 8'd1, CHIP_C2, 0, 32'hFFFF_FFFF, LEN_EXACT, 0, 0);
        make_image(MAGIC_BYTE, 8'd1, CHIP_C2, 0, 32'h0000_1000, LEN_EXACT, 0, 0);
        make_image(MAGIC_BYTE, 8'd2, CHIP_S2, 20, 0, LEN_UNDER, 0, 0);
        make_image(MAGIC_BYTE, 8'd2, CHIP_S2, 20, 0, LEN_OVER, 0, 1);

        // random images, mostly well formed
        while (bytes_to_send.size() < 1550 || images_made < 40) begin
            pick = $urandom_range(0, 99);
            d = ($urandom_range(0, 15) == 0);
            c = known_chips[$urandom_range(0, 4)];
            if (pick < 52) begin
                make_image(MAGIC_BYTE, 8'($urandom_range(1, 3)), c, 16, 0,
                           t_len_mode'($urandom_range(0, 2)), 0, d);
            end else if (pick < 55) begin
                make_image(MAGIC_BYTE, 8'($urandom_range(4, MAX_SEGMENTS_DEF)), c, 3, 0,
                           t_len_mode'($urandom_range(0, 2)), 0, d);
            end else if (pick < 62) begin
                do m = 8'($urandom); while (m == MAGIC_BYTE);
                make_image(m, 8'($urandom_range(1, 3)), c, 16, 0, LEN_EXACT, 0, d);
            end else if (pick < 68) begin
                do c = 8'($urandom);
                while (c == CHIP_BASE || c == CHIP_S2 || c == CHIP_C3 || c == CHIP_S3 ||
                       c == CHIP_C2);
                make_image(MAGIC_BYTE, 8'($urandom_range(1, 3)), c, 16, 0, LEN_EXACT, 0, d);
            end else if (pick < 74) begin
                m = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(MAX_SEGMENTS_DEF + 1, 255));
                make_image(MAGIC_BYTE, m, c, 16, 0, LEN_EXACT, 0, d);
            end else if (pick < 78) begin
                make_image(MAGIC_BYTE, 8'($urandom_range(1, 3)), c, 0,
                           $urandom | 32'h0200_0000, LEN_EXACT, 0, d);
            end else if (pick < 82) begin
                make_image(MAGIC_BYTE, 8'($urandom_range(1, 3)), c, 0,
                           $urandom_range(64, 32'h00FF_FFFF), LEN_EXACT, 0, d);
            end else if (pick < 90) begin
                make_image(MAGIC_BYTE, 8'($urandom_range(1, 3)), c, 0, 0, LEN_FIXED,
                           $urandom_range(1, HEADER_LEN - 1), d);
            end else begin
                make_image(8'($urandom), 8'($urandom), 8'($urandom), 255, 0, LEN_FIXED,
                           $urandom_range(1, 60), d);
            end
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (bytes_to_send.size() != 0 || issued_count != taken_count || image_results.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    // sender: hold an item until taken, idle in bursts except near the end
    always @(negedge i_clk) begin
        if (i_rst_n && issued_count == taken_count) begin
            if (issued_count % 128 == 0)
                gap_pct = 10 * $urandom_range(0, 2);
            if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (bytes_to_send.size() == 0 ||
                         (bytes_to_send[0].drain && image_results.size() != 0)) begin
                s_axis_tvalid <= 1'b0;
            end else if (bytes_to_send.size() >= 200 && $urandom_range(0, 99) < gap_pct) begin
                gap_left = $urandom_range(0, 6);
                s_axis_tvalid <= 1'b0;
            end else begin
                next_byte = bytes_to_send.pop_front();
                s_axis_tdata <= next_byte.data;
                s_axis_tlast <= next_byte.fin;
                s_axis_tvalid <= 1'b1;
                issued_count++;
            end
        end
    end

    // receiver: stall in bursts except near the end
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if ($urandom_range(0, 255) == 0)
                stall_pct = ($urandom_range(0, 2) == 0) ? 0 : 15 * $urandom_range(1, 3);
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (bytes_to_send.size() >= 200 && $urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(0, 6);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_end_report want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (image_results.size() == 0) begin
                    $display("%0t: result %h with none expected", $time, m_axis_tdata);
                    mismatches++;
                end else begin
                    want = image_results.pop_front();
                    if (m_axis_tdata[2:0] !== want.status) begin
                        $display("%0t: status expected %0d, got %0d", $time,
                                 want.status, m_axis_tdata[2:0]);
                        mismatches++;
                    end
                    if (m_axis_tdata[5:3] !== want.platform) begin
                        $display("%0t: platform expected %0d, got %0d", $time,
                                 want.platform, m_axis_tdata[5:3]);
                        mismatches++;
                    end
                    if (m_axis_tdata[30:6] !== want.image_end) begin
                        $display("%0t: image_end expected %0d, got %0d", $time,
                                 want.image_end, m_axis_tdata[30:6]);
                        mismatches++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                taken_count++;
                take_image_byte(s_axis_tdata, s_axis_tlast);
            end
        end
    end

endmodule
